// ===== rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg - shared types and constants
// Action codes, command kinds, field widths and palette group bases for the
// scanline palette pixel generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int ACTION_W  = 3;
    localparam int PAYLOAD_W = 32;
    localparam int COLOR_W   = 12;
    localparam int MODE_W    = 8;
    localparam int LINE_W    = 5;
    localparam int BYTE_W    = 8;

    // Input action codes
    localparam logic [ACTION_W-1:0] ACT_PIXELS  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MODE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PALETTE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LINE    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FRAME   = 3'd4;

    // Queued command kinds
    localparam logic [1:0] KIND_PIXELS  = 2'd0;
    localparam logic [1:0] KIND_MODE    = 2'd1;
    localparam logic [1:0] KIND_PALETTE = 2'd2;
    localparam logic [1:0] KIND_LINE    = 2'd3;
    // A frame start travels as a line command with this payload bit set
    localparam int FRAME_FLAG_BIT = 31;

    // Mode byte bits
    localparam int MODE_640_BIT  = 7;
    localparam int MODE_FILL_BIT = 5;

    // Palette group bases for 640 dots, in dot order
    localparam int GROUP_A = 8;
    localparam int GROUP_B = 12;
    localparam int GROUP_C = 0;
    localparam int GROUP_D = 4;

    // Entry loaded as fill colour on line zero
    localparam int LINE_ZERO_ENTRY = 2;

    // Second palette colour sits in the upper half of the payload
    localparam int COLOR_HI_LSB = 16;

    typedef struct packed {
        logic [1:0]           kind;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

endpackage

// ===== rtl/slpg_in_if.sv =====
// ----------------------------------------------------------------------------
// slpg_in_if - input action channel
// Valid/ready channel carrying one action and its 32-bit payload per beat.
// ----------------------------------------------------------------------------
interface slpg_in_if;
    import slpg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output action, output payload, input ready);
    modport sink   (input valid, input action, input payload, output ready);

endinterface

// ===== rtl/slpg_out_if.sv =====
// ----------------------------------------------------------------------------
// slpg_out_if - dot output channel
// Valid/ready channel carrying four dot colours and an end-of-word flag.
// ----------------------------------------------------------------------------
interface slpg_out_if;
    import slpg_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] dot_a;
    logic [COLOR_W-1:0] dot_b;
    logic [COLOR_W-1:0] dot_c;
    logic [COLOR_W-1:0] dot_d;
    logic               last_of_word;

    modport source (output valid, output dot_a, output dot_b, output dot_c,
                    output dot_d, output last_of_word, input ready);
    modport sink   (input valid, input dot_a, input dot_b, input dot_c,
                    input dot_d, input last_of_word, output ready);

endinterface

// ===== rtl/slpg_front.sv =====
// ----------------------------------------------------------------------------
// slpg_front - action decode and command queue
// Accepts input beats, classifies the action into a command kind, drops
// unused codes and holds commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module slpg_front
    import slpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    slpg_in_if.sink    cmd,
    output cmd_t       head,
    output logic       head_valid,
    input  logic       head_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    cmd_t             decoded;
    logic             known;
    logic             push;
    logic             pop;

    always_comb
    begin
        decoded.payload = cmd.payload;
        decoded.kind    = KIND_PIXELS;
        known           = 1'b1;
        case (cmd.action)
            ACT_PIXELS:  decoded.kind = KIND_PIXELS;
            ACT_MODE:    decoded.kind = KIND_MODE;
            ACT_PALETTE: decoded.kind = KIND_PALETTE;
            ACT_LINE:
            begin
                decoded.kind                    = KIND_LINE;
                decoded.payload[FRAME_FLAG_BIT] = 1'b0;
            end
            ACT_FRAME:
            begin
                decoded.kind                    = KIND_LINE;
                decoded.payload[FRAME_FLAG_BIT] = 1'b1;
            end
            default:     known = 1'b0;
        endcase
    end

    assign cmd.ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = cmd.valid && cmd.ready && known;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head       = queue_mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/slpg_back.sv =====
// ----------------------------------------------------------------------------
// slpg_back - palette state and dot generation
// Executes queued commands: mode, palette and line updates, and pixel
// words one byte a cycle into a registered output stage while it is free.
// ----------------------------------------------------------------------------
module slpg_back
    import slpg_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       head_pop,
    slpg_out_if.source dots
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [COLOR_W-1:0] palette_reg [TABLE_ENTRIES];
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [IDX_W-1:0]   tptr_reg, tptr_next;
    logic [COLOR_W-1:0] held_reg, held_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic               seen_reg, seen_next;
    logic [1:0]         byte_reg, byte_next;

    logic               out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] dot_a_reg, dot_b_reg, dot_c_reg, dot_d_reg;
    logic               last_reg;

    logic               out_free;
    logic               pix_fire;
    logic               pal_we;
    logic [BYTE_W-1:0]  pix;
    logic [3:0]         hi_nib, lo_nib;
    logic               fill;
    logic [COLOR_W-1:0] hi_color, lo_color;
    logic [COLOR_W-1:0] dot_a_new, dot_b_new, dot_c_new, dot_d_new;
    logic [LINE_W-1:0]  line_adv;

    assign out_free = !out_valid_reg || dots.ready;
    assign pix_fire = head_valid && (head.kind == KIND_PIXELS) && out_free;
    assign pal_we   = head_valid && (head.kind == KIND_PALETTE);

    // Select the current byte of the pixel word
    assign pix    = BYTE_W'(head.payload >> {byte_reg, 3'b000});
    assign hi_nib = pix[7:4];
    assign lo_nib = pix[3:0];
    assign fill   = mode_reg[MODE_FILL_BIT];

    // Fill mode: a zero nibble repeats the colour held so far
    assign hi_color = (fill && hi_nib == 4'd0) ? held_reg : palette_reg[IDX_W'(hi_nib)];
    assign lo_color = (fill && lo_nib == 4'd0) ? hi_color : palette_reg[IDX_W'(lo_nib)];

    assign line_adv = seen_reg ? line_reg + LINE_W'(1) : line_reg;

    always_comb
    begin
        if (mode_reg[MODE_640_BIT])
        begin
            dot_a_new = palette_reg[IDX_W'(GROUP_A) + IDX_W'(pix[7:6])];
            dot_b_new = palette_reg[IDX_W'(GROUP_B) + IDX_W'(pix[5:4])];
            dot_c_new = palette_reg[IDX_W'(GROUP_C) + IDX_W'(pix[3:2])];
            dot_d_new = palette_reg[IDX_W'(GROUP_D) + IDX_W'(pix[1:0])];
        end
        else
        begin
            dot_a_new = hi_color;
            dot_b_new = hi_color;
            dot_c_new = lo_color;
            dot_d_new = lo_color;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        tptr_next = tptr_reg;
        held_next = held_reg;
        line_next = line_reg;
        seen_next = seen_reg;
        byte_next = byte_reg;
        head_pop  = 1'b0;

        if (head_valid)
        begin
            case (head.kind)
                KIND_PIXELS:
                begin
                    if (out_free)
                    begin
                        seen_next = 1'b1;
                        byte_next = byte_reg + 2'd1;
                        head_pop  = (byte_reg == 2'd3);
                        if (!mode_reg[MODE_640_BIT])
                        begin
                            held_next = lo_color;
                        end
                    end
                end
                KIND_MODE:
                begin
                    mode_next = head.payload[MODE_W-1:0];
                    tptr_next = '0;
                    head_pop  = 1'b1;
                end
                KIND_PALETTE:
                begin
                    tptr_next = tptr_reg + IDX_W'(2);
                    head_pop  = 1'b1;
                end
                KIND_LINE:
                begin
                    head_pop = 1'b1;
                    if (head.payload[FRAME_FLAG_BIT])
                    begin
                        line_next = '0;
                        seen_next = 1'b0;
                    end
                    else
                    begin
                        line_next = line_adv;
                        held_next = (line_adv == '0)
                                  ? palette_reg[IDX_W'(LINE_ZERO_ENTRY)]
                                  : palette_reg[line_adv[IDX_W-1:0]];
                    end
                end
                default:
                begin
                    head_pop = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pix_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (dots.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            tptr_reg      <= '0;
            held_reg      <= '0;
            line_reg      <= '0;
            seen_reg      <= 1'b0;
            byte_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            tptr_reg      <= tptr_next;
            held_reg      <= held_next;
            line_reg      <= line_next;
            seen_reg      <= seen_next;
            byte_reg      <= byte_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (pal_we)
        begin
            palette_reg[tptr_reg]            <= head.payload[COLOR_W-1:0];
            palette_reg[tptr_reg + IDX_W'(1)] <=
                head.payload[COLOR_HI_LSB +: COLOR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            dot_a_reg <= dot_a_new;
            dot_b_reg <= dot_b_new;
            dot_c_reg <= dot_c_new;
            dot_d_reg <= dot_d_new;
            last_reg  <= (byte_reg == 2'd3);
        end
    end

    assign dots.valid        = out_valid_reg;
    assign dots.dot_a        = dot_a_reg;
    assign dots.dot_b        = dot_b_reg;
    assign dots.dot_c        = dot_c_reg;
    assign dots.dot_d        = dot_d_reg;
    assign dots.last_of_word = last_reg;

endmodule

// ===== rtl/scanline_palette_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// scanline_palette_pixel_generator_core - super-hires scanline dot generator
// 320/640 palette video: action decode and queue feeding a palette and dot
// back end with a registered output stage.
//
//   channel   dir   beat contents
//   cmd       in    action (3), payload (32)
//   dots      out   dot_a..dot_d (12 each), last_of_word
//
// A pixel word gives four output beats, one per cycle while dots is not
// stalled, as the back end emits one byte's dots a cycle; the next word
// is taken only after the fourth. Mode, palette, line and frame actions
// are each applied as they reach the back end. Dot results are registered;
// a two-entry queue lets cmd accept while dots is stalled until it fills.
// Reset clears the palette, mode, pointers, counts and the queue.
// ----------------------------------------------------------------------------
module scanline_palette_pixel_generator_core
    import slpg_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    slpg_in_if.sink    cmd,
    slpg_out_if.source dots
);

    cmd_t head;
    logic head_valid;
    logic head_pop;

    slpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    slpg_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .dots       (dots)
    );

endmodule
